/* design/lbp_pkg.sv */
// Shared types and constants for the LSB-first bit packer.
package lbp_pkg;

  // Default largest field width in bits
  localparam int MaxFieldBitsDef = 32;

  // Width of the value field on the input channel
  localparam int ValueBits = 32;

  // Function codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    FUNC_RAW    = 2'd0,
    FUNC_ZIGZAG = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  // Input transaction
  typedef struct packed {
    func_e                func;
    logic [ValueBits-1:0] data_value;
    logic [5:0]           field_width;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       last_in_run;
  } out_t;

endpackage

/* design/lbp_pack.sv */
// Input register, pending-bit state and the packing logic of the bit packer.
module lbp_pack #(
  parameter int MaxFieldBits = lbp_pkg::MaxFieldBitsDef,
  localparam int AccBits  = MaxFieldBits + 7,
  localparam int MaxBytes = AccBits / 8,
  localparam int CntW     = $clog2(MaxBytes + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lbp_pkg::in_t            in_data_i,
  output logic                    run_valid_o,
  output logic [MaxBytes*8-1:0]   run_bytes_o,
  output logic [CntW-1:0]         run_count_o,
  input  logic                    run_ready_i
);

  localparam int TotW = $clog2(AccBits + 1);
  localparam logic [6:0] MaxW = 7'(MaxFieldBits);

  lbp_pkg::in_t item_q;
  logic         full_q;
  logic [6:0]   acc_q, acc_d;
  logic [2:0]   pend_q, pend_d;

  logic                    advance;
  logic                    accept;
  logic [6:0]              eff_width;
  logic [31:0]             field_val;
  logic [31:0]             field_mask;
  logic [AccBits-1:0]      acc_wide;
  logic [AccBits-1:0]      acc_rest;
  logic [TotW-1:0]         total;
  logic [CntW-1:0]         nbytes;

  // Clamp the width to 1..MaxFieldBits
  always_comb begin
    if (item_q.field_width == 6'd0) begin
      eff_width = 7'd1;
    end else if ({1'b0, item_q.field_width} > MaxW) begin
      eff_width = MaxW;
    end else begin
      eff_width = {1'b0, item_q.field_width};
    end
  end

  // Zigzag-encode signed fields, then mask to the width
  always_comb begin
    if (item_q.func == lbp_pkg::FUNC_ZIGZAG) begin
      field_val = {item_q.data_value[30:0], 1'b0} ^ {32{item_q.data_value[31]}};
    end else begin
      field_val = item_q.data_value;
    end
    if (eff_width < 7'd32) begin
      field_mask = 32'((33'd1 << eff_width[4:0]) - 33'd1);
    end else begin
      field_mask = '1;
    end
  end

  // Append the field above the pending bits and split off whole bytes
  assign acc_wide = AccBits'(acc_q) | (AccBits'(field_val & field_mask) << pend_q);
  assign total    = TotW'(pend_q) + TotW'(eff_width);
  assign nbytes   = CntW'(total >> 3);
  assign acc_rest = acc_wide >> {nbytes, 3'b000};

  // Select the run of bytes and the next pending state per function
  always_comb begin
    run_bytes_o = acc_wide[MaxBytes*8-1:0];
    run_count_o = '0;
    acc_d       = acc_q;
    pend_d      = pend_q;
    case (item_q.func)
      lbp_pkg::FUNC_RAW, lbp_pkg::FUNC_ZIGZAG: begin
        run_count_o = nbytes;
        acc_d       = acc_rest[6:0];
        pend_d      = total[2:0];
      end
      lbp_pkg::FUNC_FLUSH: begin
        run_bytes_o = (MaxBytes*8)'(acc_q);
        if (pend_q != 3'd0) begin
          run_count_o = CntW'(1);
        end
        acc_d  = '0;
        pend_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Items without bytes leave at once; others wait for the byte buffer
  assign run_valid_o = full_q && (run_count_o != '0);
  assign advance     = full_q && ((run_count_o == '0) || run_ready_i);
  assign in_stall_o  = full_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;

  // Hold the control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      acc_q  <= '0;
      pend_q <= '0;
    end else begin
      if (accept) begin
        full_q <= 1'b1;
      end else if (advance) begin
        full_q <= 1'b0;
      end
      if (advance) begin
        acc_q  <= acc_d;
        pend_q <= pend_d;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

endmodule

/* design/lbp_emit.sv */
// Byte buffer that hands out one packed byte per output transaction.
module lbp_emit #(
  parameter int MaxFieldBits = lbp_pkg::MaxFieldBitsDef,
  localparam int AccBits  = MaxFieldBits + 7,
  localparam int MaxBytes = AccBits / 8,
  localparam int CntW     = $clog2(MaxBytes + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  run_valid_i,
  input  logic [MaxBytes*8-1:0] run_bytes_i,
  input  logic [CntW-1:0]       run_count_i,
  output logic                  run_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output lbp_pkg::out_t         out_data_o
);

  logic [MaxBytes*8-1:0] buf_q;
  logic [CntW-1:0]       left_q;
  logic                  out_take;
  logic                  load;

  // Present the lowest buffered byte
  assign out_valid_o            = left_q != '0;
  assign out_data_o.packed_byte = buf_q[7:0];
  assign out_data_o.last_in_run = left_q == CntW'(1);
  assign out_take               = out_valid_o && !out_stall_i;

  // Take a new run when empty or when the last byte leaves now
  assign run_ready_o = (left_q == '0) || ((left_q == CntW'(1)) && out_take);
  assign load        = run_valid_i && run_ready_o;

  // Advance the byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (load) begin
      left_q <= run_count_i;
    end else if (out_take) begin
      left_q <= left_q - CntW'(1);
    end
  end

  // Load or shift the byte data
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= run_bytes_i;
    end else if (out_take) begin
      buf_q <= buf_q >> 8;
    end
  end

endmodule

/* design/lsb_first_bit_packer_unit.sv */
// LSB-first bit packer: fields in, packed bytes out, with zigzag and flush.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// field or flush. Output channel (out_valid_o / out_stall_i / out_data_o):
// one transaction per completed byte, earliest bit in bit 0; last_in_run
// marks the final byte caused by one input transaction.
// An input transaction lands in the input register; the packing logic then
// loads its bytes into the byte buffer once the buffer takes the run, and
// the buffer takes the next run as the last byte of its current run leaves.
// Bytes leave one per cycle while the receiver does not stall. An input
// completes up to (MAX_FIELD_BITS + 7) / 8 bytes, 4 at the default of 32
// bits; inputs completing no byte skip the byte buffer. While the receiver
// stalls, the buffer holds its byte, the input register fills and then
// in_stall_o rises. Reset empties both registers and clears the pending
// bits; no clearing pass is needed.
module lsb_first_bit_packer_unit #(
  parameter int MAX_FIELD_BITS = lbp_pkg::MaxFieldBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lbp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lbp_pkg::out_t out_data_o
);

  localparam int AccBits  = MAX_FIELD_BITS + 7;
  localparam int MaxBytes = AccBits / 8;
  localparam int CntW     = $clog2(MaxBytes + 1);

  logic                  run_valid;
  logic                  run_ready;
  logic [MaxBytes*8-1:0] run_bytes;
  logic [CntW-1:0]       run_count;

  // Pack fields into runs of whole bytes
  lbp_pack #(
    .MaxFieldBits(MAX_FIELD_BITS)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .run_valid_o (run_valid),
    .run_bytes_o (run_bytes),
    .run_count_o (run_count),
    .run_ready_i (run_ready)
  );

  // Emit bytes one per transaction
  lbp_emit #(
    .MaxFieldBits(MAX_FIELD_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_bytes_i (run_bytes),
    .run_count_i (run_count),
    .run_ready_o (run_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A run handed over never exceeds the buffer and is never empty
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid |-> (run_count != '0) && (run_count <= CntW'(MaxBytes)))
    else $error("run byte count out of range");

  // A loaded run shows a byte at the next cycle
  a_run_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid && run_ready |=> out_valid_o)
    else $error("loaded run produced no byte");

  // A byte that is not last is followed by more bytes of its run
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_in_run |=> out_valid_o)
    else $error("run ended without a last byte");

  // The buffer accepts no new run while a non-last byte waits
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_in_run |-> !run_ready)
    else $error("buffer ready in the middle of a run");

endmodule

/* tb/lbp_byte_checker.sv */
// Checker for the bit packer: predicts the byte stream and compares each output transaction.
module lbp_byte_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  lbp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  lbp_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            bytes_owed_o,
  output int            fields_seen_o,
  output int            bytes_seen_o
);

  // Predicted stream state: pending bits, earliest in bit 0
  logic [38:0]   acc_bits;
  int            pend_bits;
  lbp_pkg::out_t bytes_due[$];
  int            fails;
  int            fields_seen;
  int            bytes_seen;

  // Append one field (or flush) and queue the bytes it completes
  function automatic void pack_field(input lbp_pkg::in_t t);
    logic [31:0]   v;
    logic [63:0]   acc;
    int            w;
    int            total;
    int            n;
    lbp_pkg::out_t b;
    n = 0;
    case (t.func)
      lbp_pkg::FUNC_FLUSH: begin
        if (pend_bits != 0) begin
          b.packed_byte = acc_bits[7:0];
          b.last_in_run = 1'b1;
          bytes_due.insert(bytes_due.size(), b);
          acc_bits  = '0;
          pend_bits = 0;
        end
      end
      lbp_pkg::FUNC_RAW, lbp_pkg::FUNC_ZIGZAG: begin
        w = int'(t.field_width);
        if (w == 0) w = 1;
        if (w > lbp_pkg::MaxFieldBitsDef) w = lbp_pkg::MaxFieldBitsDef;
        v = t.data_value;
        // zigzag over all 32 bits, then mask
        if (t.func == lbp_pkg::FUNC_ZIGZAG) v = {v[30:0], 1'b0} ^ {32{v[31]}};
        if (w < 32) v = v & ((32'd1 << w) - 32'd1);
        acc   = {57'd0, acc_bits[6:0]} | ({32'd0, v} << pend_bits);
        total = pend_bits + w;
        while (total >= 8) begin
          b.packed_byte = acc[7:0];
          b.last_in_run = 1'b0;
          bytes_due.insert(bytes_due.size(), b);
          acc   = acc >> 8;
          total = total - 8;
          n++;
        end
        if (n > 0) bytes_due[bytes_due.size()-1].last_in_run = 1'b1;
        acc_bits  = acc[38:0];
        pend_bits = total;
      end
      default: ;  // unused code: drop
    endcase
  endfunction

  // Check output transactions first, then predict from input transactions
  always @(posedge clk_i or negedge rst_ni) begin
    lbp_pkg::out_t exp_b;
    if (!rst_ni) begin
      acc_bits    = '0;
      pend_bits   = 0;
      fails       = 0;
      fields_seen = 0;
      bytes_seen  = 0;
      bytes_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        bytes_seen++;
        if (bytes_due.size() == 0) begin
          $error("unexpected output byte 0x%02h last %0b",
                 out_data_i.packed_byte, out_data_i.last_in_run);
          fails++;
        end else begin
          exp_b = bytes_due.pop_front();
          if (out_data_i.packed_byte !== exp_b.packed_byte) begin
            $error("packed_byte: expected 0x%02h, got 0x%02h",
                   exp_b.packed_byte, out_data_i.packed_byte);
            fails++;
          end
          if (out_data_i.last_in_run !== exp_b.last_in_run) begin
            $error("last_in_run: expected %0b, got %0b",
                   exp_b.last_in_run, out_data_i.last_in_run);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        fields_seen++;
        pack_field(in_data_i);
      end
    end
    fail_count_o  <= fails;
    bytes_owed_o  <= bytes_due.size();
    fields_seen_o <= fields_seen;
    bytes_seen_o  <= bytes_seen;
  end

endmodule

/* tb/tb.sv */
// Top of the bit packer testbench: clock, reset, stimulus and verdict.
module tb;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int         HoldCycles = 150;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  lbp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  lbp_pkg::out_t out_data;

  int fail_count;
  int bytes_owed;
  int fields_seen;
  int bytes_seen;

  int idle_pct;
  int stall_pct;
  bit hold_req;

  lsb_first_bit_packer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  lbp_byte_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .bytes_owed_o  (bytes_owed),
    .fields_seen_o (fields_seen),
    .bytes_seen_o  (bytes_seen)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #4_000_000;
    $display("lsb_first_bit_packer_unit test failed");
    $finish;
  end

  // Receiver: random stalls, or one long hold when requested
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic lbp_pkg::in_t mk_field(input logic [1:0] f, input logic [31:0] v,
                                            input logic [5:0] w);
    lbp_pkg::in_t t;
    t.func        = lbp_pkg::func_e'(f);
    t.data_value  = v;
    t.field_width = w;
    return t;
  endfunction

  // Random field: mostly raw and zigzag, some flushes and unused codes
  function automatic lbp_pkg::in_t rand_field();
    logic [1:0]  f;
    logic [31:0] v;
    logic [5:0]  w;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 45) f = lbp_pkg::FUNC_RAW;
    else if (r < 85) f = lbp_pkg::FUNC_ZIGZAG;
    else if (r < 95) f = lbp_pkg::FUNC_FLUSH;
    else f = FuncUnused;
    r = $urandom_range(0, 99);
    if (r < 70) v = $urandom;
    else if (r < 85) v = $urandom_range(0, 15) - 8;
    else begin
      case ($urandom_range(0, 3))
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h8000_0000;
        default: v = 32'h7FFF_FFFF;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 60) w = 6'($urandom_range(0, 63));
    else if (r < 85) w = 6'($urandom_range(1, 8));
    else begin
      case ($urandom_range(0, 5))
        0:       w = 6'd0;
        1:       w = 6'd1;
        2:       w = 6'd31;
        3:       w = 6'd32;
        4:       w = 6'd33;
        default: w = 6'd63;
      endcase
    end
    return mk_field(f, v, w);
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic offer(input lbp_pkg::in_t t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Run random transactions until enough non-ignored ones have gone in
  task automatic random_phase(input int count, input int idle, input int stall);
    lbp_pkg::in_t t;
    int           done;
    idle_pct  = idle;
    stall_pct = stall;
    done      = 0;
    while (done < count) begin
      t = rand_field();
      offer(t);
      if (t.func != lbp_pkg::func_e'(FuncUnused)) done++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    int waited;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every function, corner cases
    offer(mk_field(lbp_pkg::FUNC_FLUSH,  32'h0000_0000, 6'd0));   // flush, nothing pending
    offer(mk_field(FuncUnused,           32'hFFFF_FFFF, 6'd63));  // unused code, ignored
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'h0000_0000, 6'd0));   // width zero
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'hFFFF_FFFF, 6'd0));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'h0000_0005, 6'd6));   // completes a byte
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'hFFFF_FFFF, 6'd32));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'hFFFF_FFFF, 6'd63));  // width clamped
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'hFFFF_FFFF, 6'd3));   // upper bits masked
    offer(mk_field(lbp_pkg::FUNC_FLUSH,  32'hFFFF_FFFF, 6'd63));
    offer(mk_field(lbp_pkg::FUNC_FLUSH,  32'h0000_0000, 6'd0));   // second flush is a no-op
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'hFFFF_FFFF, 6'd32));  // -1
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'h8000_0000, 6'd32));  // most negative
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'h7FFF_FFFF, 6'd32));  // most positive
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'h0000_0000, 6'd5));
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'hFFFF_FFFE, 6'd7));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'h0000_00AA, 6'd8));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'h1234_5678, 6'd31));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'hDEAD_BEEF, 6'd33));
    offer(mk_field(lbp_pkg::FUNC_ZIGZAG, 32'h5555_5555, 6'd1));
    offer(mk_field(FuncUnused,           32'h0000_0000, 6'd0));   // ignored with bits pending
    offer(mk_field(lbp_pkg::FUNC_FLUSH,  32'h0000_0000, 6'd0));
    offer(mk_field(lbp_pkg::FUNC_RAW,    32'h0000_0000, 6'd32));

    // Random: back-to-back with a long output hold, then the idle/stall mixes
    hold_req = 1'b1;
    random_phase(75, 0, 0);
    random_phase(75, 58, 0);
    random_phase(75, 0, 58);
    random_phase(75, 33, 33);
    in_valid <= 1'b0;

    // Drain: wait for every predicted byte, then idle on before the verdict
    stall_pct = 0;
    @(posedge clk_i);
    waited = 0;
    while (bytes_owed != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input transactions and %0d output bytes,", fields_seen,
             bytes_seen);
    $display("with directed corner cases, four idle/stall mixes and one long output hold.");
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("lsb_first_bit_packer_unit test passed");
    end else begin
      if (bytes_owed != 0) $error("%0d expected bytes never arrived", bytes_owed);
      $display("lsb_first_bit_packer_unit test failed");
    end
    $finish;
  end

endmodule
